// ===== hw/rtl/tcw_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the text console writer.
package tcw_pkg;

    // Default geometry
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // Field widths
    localparam int FUNC_W   = 2;
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int COL_IN_W = 7;
    localparam int ROW_IN_W = 5;
    localparam int CURSOR_W = 11;
    localparam int CELL_W   = CHAR_W + ATTR_W;

    // Stream widths
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = FUNC_W;
    localparam int M_TDATA_W = 32;

    // Operation codes
    localparam logic [FUNC_W-1:0] FN_PUT   = 2'd0;
    localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd1;
    localparam logic [FUNC_W-1:0] FN_READ  = 2'd2;

    // Character codes
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;

    localparam logic [ATTR_W-1:0] DEF_ATTR_RESET = 8'd15;

    // Memory write source select
    localparam logic [1:0] WR_NONE = 2'd0;
    localparam logic [1:0] WR_PUT  = 2'd1;
    localparam logic [1:0] WR_FILL = 2'd2;
    localparam logic [1:0] WR_COPY = 2'd3;

    // Memory read address select
    localparam logic [1:0] RD_NONE = 2'd0;
    localparam logic [1:0] RD_CELL = 2'd1;
    localparam logic [1:0] RD_COPY = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [CHAR_W-1:0]   char_code;
        logic [ATTR_W-1:0]   attribute;
        logic                use_position;
        logic [COL_IN_W-1:0] column;
        logic [ROW_IN_W-1:0] row;
    } item_t;

    typedef struct packed {
        logic [CURSOR_W-1:0] cursor;
        logic [CHAR_W-1:0]   cell_char;
        logic [ATTR_W-1:0]   cell_attr;
        logic                scrolled;
    } result_t;

    typedef struct packed {
        logic       load_item;
        logic       put_exec;
        logic       cnt_clr;
        logic       cnt_inc;
        logic [1:0] wr_sel;
        logic       fill_blank;
        logic [1:0] rd_sel;
        logic       home;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              put_wrap;
        logic              cnt_zero;
        logic              cnt_copy_end;
        logic              cnt_last;
    } status_t;

endpackage

// ===== hw/rtl/text_console_writer.sv =====
// Top level of the text console writer: stream ports, attribute register and checks.
// A new item is accepted only after the previous one has finished executing (s_tready is high
// only in the idle state); the single write port and registered read port of the cell memory
// set the sweep lengths of scroll and clear.
// Reset (aresetn low, synchronous): cursor homes, attribute register returns to 15, then a
// clearing pass zeroes all COLUMNS*ROWS cells with s_tready low.
module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // s_tdata: char_code[7:0], attribute[15:8], use_position[16], column[23:17],
    // row[28:24], zero fill[31:29]
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tcw_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: func[1:0]
    input  logic [tcw_pkg::S_TUSER_W-1:0]  s_tuser,
    // m_tdata: cursor[10:0], cell_char[18:11], cell_attr[26:19], scrolled[27],
    // zero fill[31:28]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [tcw_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tcw_pkg::ATTR_W-1:0]     cfg_data
);

    localparam int CELLS   = COLUMNS * ROWS;
    localparam int OUT_W   = tcw_pkg::CURSOR_W + tcw_pkg::CHAR_W + tcw_pkg::ATTR_W + 1;
    localparam int SCR_BIT = OUT_W - 1;

    logic [tcw_pkg::ATTR_W-1:0] default_attr_reg;
    tcw_pkg::item_t             item;
    tcw_pkg::result_t           result;
    tcw_pkg::cmd_t              cmd;
    tcw_pkg::status_t           status;

    // Configuration: the user must write the register only while the block is idle (the block
    // does not enforce this), so accept every transaction at once
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_attr_reg <= tcw_pkg::DEF_ATTR_RESET;
        end else if (cfg_valid) begin
            default_attr_reg <= cfg_data;
        end
    end

    // Unpack the input transaction
    assign item.func         = s_tuser;
    assign item.char_code    = s_tdata[7:0];
    assign item.attribute    = s_tdata[15:8];
    assign item.use_position = s_tdata[16];
    assign item.column       = s_tdata[23:17];
    assign item.row          = s_tdata[28:24];

    tcw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_in      (item),
        .default_attr (default_attr_reg),
        .cmd          (cmd),
        .status       (status),
        .result       (result)
    );

    // Pack the result transaction, cursor in the lowest bits
    assign m_tdata = {(tcw_pkg::M_TDATA_W - OUT_W)'(0),
                      result.scrolled, result.cell_attr, result.cell_char, result.cursor};

    // A scroll always leaves the cursor at the start of the bottom row
    a_scroll_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[SCR_BIT])
        |-> (m_tdata[tcw_pkg::CURSOR_W-1:0] == tcw_pkg::CURSOR_W'(CELLS - COLUMNS)))
        else $error("scrolled result with cursor off the bottom row start");

    // s_tready is low in the cycle after an item is accepted, while that item executes
    a_accept_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    // A new result appears only from an executing or draining state
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result raised while the block was idle");

endmodule

// ===== hw/rtl/tcw_ctrl.sv =====
// Sequencing state machine for the text console writer.
module tcw_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  tcw_pkg::status_t status,
    output tcw_pkg::cmd_t    cmd
);

    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_EXEC   = 3'd2;
    localparam logic [2:0] ST_SCROLL = 3'd3;
    localparam logic [2:0] ST_ZERO   = 3'd4;
    localparam logic [2:0] ST_CLEAR  = 3'd5;
    localparam logic [2:0] ST_RDOUT  = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_INIT: begin
                cmd.wr_sel = tcw_pkg::WR_FILL;
                if (status.cnt_last) begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = ST_IDLE;
                end else begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (status.func)
                    tcw_pkg::FN_PUT: begin
                        cmd.put_exec = 1'b1;
                        cmd.wr_sel   = tcw_pkg::WR_PUT;
                        if (status.put_wrap) begin
                            cmd.cnt_clr = 1'b1;
                            state_next  = ST_SCROLL;
                        end else if (out_free) begin
                            cmd.out_load = 1'b1;
                            state_next   = ST_IDLE;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end
                    tcw_pkg::FN_CLEAR: begin
                        cmd.cnt_clr = 1'b1;
                        state_next  = ST_CLEAR;
                    end
                    tcw_pkg::FN_READ: begin
                        cmd.rd_sel = tcw_pkg::RD_CELL;
                        state_next = ST_RDOUT;
                    end
                    default: begin
                        // no operation: report the cursor only
                        if (out_free) begin
                            cmd.out_load = 1'b1;
                            state_next   = ST_IDLE;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end
                endcase
            end
            ST_SCROLL: begin
                // read one row ahead, write back the word read last cycle
                if (!status.cnt_copy_end) begin
                    cmd.rd_sel = tcw_pkg::RD_COPY;
                end
                if (!status.cnt_zero) begin
                    cmd.wr_sel = tcw_pkg::WR_COPY;
                end
                // hold the count at the bottom row start so zeroing begins there
                if (status.cnt_copy_end) begin
                    state_next = ST_ZERO;
                end else begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            ST_ZERO, ST_CLEAR: begin
                cmd.wr_sel     = tcw_pkg::WR_FILL;
                cmd.fill_blank = (state_reg == ST_CLEAR);
                if (status.cnt_last) begin
                    cmd.cnt_clr = 1'b1;
                    cmd.home    = (state_reg == ST_CLEAR);
                    if (out_free) begin
                        cmd.out_load = 1'b1;
                        state_next   = ST_IDLE;
                    end else begin
                        state_next = ST_DONE;
                    end
                end else begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            ST_RDOUT, ST_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

// ===== hw/rtl/tcw_datapath.sv =====
// Cell buffer, cursor, sweep counter and result register of the text console writer.
module tcw_datapath #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  tcw_pkg::item_t              item_in,
    input  logic [tcw_pkg::ATTR_W-1:0]  default_attr,
    input  tcw_pkg::cmd_t               cmd,
    output tcw_pkg::status_t            status,
    output tcw_pkg::result_t            result
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int LIN_W = $clog2(CELLS);
    localparam int COL_W = $clog2(COLUMNS);
    localparam int ROW_W = $clog2(ROWS);

    localparam logic [LIN_W-1:0] COLS_L    = LIN_W'(COLUMNS);
    localparam logic [LIN_W-1:0] LAST_CELL = LIN_W'(CELLS - 1);
    localparam logic [LIN_W-1:0] COPY_END  = LIN_W'(CELLS - COLUMNS);
    localparam logic [COL_W-1:0] LAST_COL  = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(ROWS - 1);

    logic [tcw_pkg::CELL_W-1:0] cells_reg [CELLS];
    logic [tcw_pkg::CELL_W-1:0] rd_data_reg;

    logic [LIN_W-1:0] cur_lin_reg, cur_lin_next;
    logic [ROW_W-1:0] cur_row_reg, cur_row_next;
    logic [COL_W-1:0] cur_col_reg, cur_col_next;
    logic             scroll_reg, scroll_next;
    logic [LIN_W-1:0] cnt_reg, cnt_next;

    logic [LIN_W-1:0]             pos_lin_reg;
    logic [ROW_W-1:0]             pos_row_reg;
    logic [COL_W-1:0]             pos_col_reg;
    logic [tcw_pkg::FUNC_W-1:0]   func_reg;
    logic [tcw_pkg::CHAR_W-1:0]   char_reg;
    logic [tcw_pkg::ATTR_W-1:0]   attr_reg;
    tcw_pkg::result_t             result_reg, result_next;

    logic [COL_W-1:0] sat_col;
    logic [ROW_W-1:0] sat_row;
    logic [LIN_W-1:0] in_lin;
    logic             positioned;

    logic             newline;
    logic             row_adv;
    logic             put_wrap;
    logic [LIN_W-1:0] row_base;

    logic                       wr_en;
    logic [LIN_W-1:0]           wr_addr;
    logic [tcw_pkg::CELL_W-1:0] wr_data;
    logic                       rd_en;
    logic [LIN_W-1:0]           rd_addr;

    // Saturate the given position and form its cell index
    assign sat_col    = (int'(item_in.column) >= COLUMNS) ? LAST_COL : COL_W'(item_in.column);
    assign sat_row    = (int'(item_in.row) >= ROWS) ? LAST_ROW : ROW_W'(item_in.row);
    assign in_lin     = LIN_W'(sat_row) * COLS_L + LIN_W'(sat_col);
    assign positioned = item_in.use_position || (item_in.func == tcw_pkg::FN_READ);

    // Cursor advance for a put
    assign newline  = (char_reg == tcw_pkg::NEWLINE_CODE);
    assign row_adv  = newline || (pos_col_reg == LAST_COL);
    assign put_wrap = row_adv && (pos_row_reg == LAST_ROW);
    assign row_base = pos_lin_reg - LIN_W'(pos_col_reg);

    always_comb begin
        cur_lin_next = cur_lin_reg;
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        if (cmd.home) begin
            cur_lin_next = '0;
            cur_row_next = '0;
            cur_col_next = '0;
        end else if (cmd.put_exec) begin
            if (put_wrap) begin
                cur_lin_next = row_base;
                cur_row_next = LAST_ROW;
                cur_col_next = '0;
            end else if (row_adv) begin
                cur_lin_next = row_base + COLS_L;
                cur_row_next = pos_row_reg + ROW_W'(1);
                cur_col_next = '0;
            end else begin
                cur_lin_next = pos_lin_reg + LIN_W'(1);
                cur_row_next = pos_row_reg;
                cur_col_next = pos_col_reg + COL_W'(1);
            end
        end
    end

    always_comb begin
        if (cmd.load_item) begin
            scroll_next = 1'b0;
        end else if (cmd.put_exec) begin
            scroll_next = put_wrap;
        end else begin
            scroll_next = scroll_reg;
        end
    end

    always_comb begin
        if (cmd.cnt_clr) begin
            cnt_next = '0;
        end else if (cmd.cnt_inc) begin
            cnt_next = cnt_reg + LIN_W'(1);
        end else begin
            cnt_next = cnt_reg;
        end
    end

    // Memory port select
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = cnt_reg;
        wr_data = '0;
        unique case (cmd.wr_sel)
            tcw_pkg::WR_PUT: begin
                wr_en   = !newline;
                wr_addr = pos_lin_reg;
                wr_data = {attr_reg, char_reg};
            end
            tcw_pkg::WR_FILL: begin
                wr_en   = 1'b1;
                wr_addr = cnt_reg;
                wr_data = cmd.fill_blank ? {default_attr, tcw_pkg::SPACE_CODE} : '0;
            end
            tcw_pkg::WR_COPY: begin
                wr_en   = 1'b1;
                wr_addr = cnt_reg - LIN_W'(1);
                wr_data = rd_data_reg;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    assign rd_en   = (cmd.rd_sel != tcw_pkg::RD_NONE);
    assign rd_addr = (cmd.rd_sel == tcw_pkg::RD_CELL) ? pos_lin_reg : cnt_reg + COLS_L;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            cells_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= cells_reg[rd_addr];
        end
    end

    always_comb begin
        result_next.cursor    = tcw_pkg::CURSOR_W'(cur_lin_next);
        result_next.cell_char = (func_reg == tcw_pkg::FN_READ)
                              ? rd_data_reg[tcw_pkg::CHAR_W-1:0] : '0;
        result_next.cell_attr = (func_reg == tcw_pkg::FN_READ)
                              ? rd_data_reg[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W] : '0;
        result_next.scrolled  = scroll_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_lin_reg <= '0;
            cur_row_reg <= '0;
            cur_col_reg <= '0;
            scroll_reg  <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            cur_lin_reg <= cur_lin_next;
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
            scroll_reg  <= scroll_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            func_reg    <= item_in.func;
            char_reg    <= item_in.char_code;
            attr_reg    <= (item_in.attribute == '0) ? default_attr : item_in.attribute;
            pos_lin_reg <= positioned ? in_lin : cur_lin_reg;
            pos_row_reg <= positioned ? sat_row : cur_row_reg;
            pos_col_reg <= positioned ? sat_col : cur_col_reg;
        end
        if (cmd.out_load) begin
            result_reg <= result_next;
        end
    end

    assign status.func         = func_reg;
    assign status.put_wrap     = put_wrap;
    assign status.cnt_zero     = (cnt_reg == '0);
    assign status.cnt_copy_end = (cnt_reg == COPY_END);
    assign status.cnt_last     = (cnt_reg == LAST_CELL);
    assign result              = result_reg;

endmodule
